// ===== rtl/etl_pkg.sv =====
// Shared types, token kind codes and character class functions for the expression lexer.
package etl_pkg;

  // Token kind codes
  localparam logic [4:0] KIND_SYMBOL  = 5'd0;
  localparam logic [4:0] KIND_NUMBER  = 5'd1;
  localparam logic [4:0] KIND_LPAREN  = 5'd2;
  localparam logic [4:0] KIND_RPAREN  = 5'd3;
  localparam logic [4:0] KIND_COMMA   = 5'd4;
  localparam logic [4:0] KIND_CARET   = 5'd5;
  localparam logic [4:0] KIND_PERCENT = 5'd6;
  localparam logic [4:0] KIND_PLUS    = 5'd7;
  localparam logic [4:0] KIND_MINUS   = 5'd8;
  localparam logic [4:0] KIND_TILDE   = 5'd9;
  localparam logic [4:0] KIND_DSLASH  = 5'd10;
  localparam logic [4:0] KIND_SLASH   = 5'd11;
  localparam logic [4:0] KIND_DSTAR   = 5'd12;
  localparam logic [4:0] KIND_STAR    = 5'd13;
  localparam logic [4:0] KIND_OROR    = 5'd14;
  localparam logic [4:0] KIND_OR      = 5'd15;
  localparam logic [4:0] KIND_ANDAND  = 5'd16;
  localparam logic [4:0] KIND_AND     = 5'd17;
  localparam logic [4:0] KIND_NE      = 5'd18;
  localparam logic [4:0] KIND_NOT     = 5'd19;
  localparam logic [4:0] KIND_EQ      = 5'd20;
  localparam logic [4:0] KIND_GE      = 5'd21;
  localparam logic [4:0] KIND_SHR     = 5'd22;
  localparam logic [4:0] KIND_GT      = 5'd23;
  localparam logic [4:0] KIND_LE      = 5'd24;
  localparam logic [4:0] KIND_SHL     = 5'd25;
  localparam logic [4:0] KIND_LT      = 5'd26;
  localparam logic [4:0] KIND_END     = 5'd27;
  localparam logic [4:0] KIND_ERROR   = 5'd28;

  // Saturation limits
  localparam logic [15:0] LEN_MAX  = 16'hFFFF;
  localparam logic [15:0] COL_MAX  = 16'hFFFF;
  localparam logic [23:0] LINE_MAX = 24'hFFFFFF;

  // Most tokens one byte can produce
  localparam int unsigned MAX_TOKENS = 3;

  // Input request
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } byte_t;

  // Output token
  typedef struct packed {
    logic [4:0]  token_kind;
    logic [31:0] token_start;
    logic [15:0] token_length;
    logic [23:0] line_number;
    logic [15:0] column_number;
    logic        last_result;
  } token_t;

  // All tokens produced by one byte
  typedef struct packed {
    logic [1:0]                    cnt;
    token_t [MAX_TOKENS-1:0]       item;
  } group_t;

  function automatic token_t make_token(logic [4:0] kind, logic [31:0] start,
                                        logic [15:0] len, logic [23:0] line,
                                        logic [15:0] col);
    token_t t;
    t.token_kind    = kind;
    t.token_start   = start;
    t.token_length  = len;
    t.line_number   = line;
    t.column_number = col;
    t.last_result   = 1'b0;
    return t;
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return (b >= "0") && (b <= "9");
  endfunction

  function automatic logic is_alpha(logic [7:0] b);
    return ((b >= "A") && (b <= "Z")) || ((b >= "a") && (b <= "z"));
  endfunction

  function automatic logic is_hexset(logic [7:0] b);
    return is_digit(b) || (b == "x") || (b == "X") || (b == "b") || (b == "B") ||
           ((b >= "a") && (b <= "f")) || ((b >= "A") && (b <= "F"));
  endfunction

  function automatic logic is_suffix(logic [7:0] b);
    return (b == "L") || (b == "U") || (b == "l") || (b == "u");
  endfunction

  // Two-character operator kind, or KIND_SYMBOL when the pair does not combine
  function automatic logic [4:0] pair_kind(logic [7:0] h, logic [7:0] b);
    logic [4:0] k;
    k = KIND_SYMBOL;
    case (h)
      "/": if (b == "/") k = KIND_DSLASH;
      "*": if (b == "*") k = KIND_DSTAR;
      "|": if (b == "|") k = KIND_OROR;
      "&": if (b == "&") k = KIND_ANDAND;
      "!": if (b == "=") k = KIND_NE;
      "=": if (b == "=") k = KIND_EQ;
      ">": begin
        if (b == "=") k = KIND_GE;
        else if (b == ">") k = KIND_SHR;
      end
      "<": begin
        if (b == "=") k = KIND_LE;
        else if (b == "<") k = KIND_SHL;
      end
      default: k = KIND_SYMBOL;
    endcase
    return k;
  endfunction

  // One-character form of a held operator; a lone '=' is an error
  function automatic logic [4:0] single_kind(logic [7:0] h);
    logic [4:0] k;
    case (h)
      "/":     k = KIND_SLASH;
      "*":     k = KIND_STAR;
      "|":     k = KIND_OR;
      "&":     k = KIND_AND;
      "!":     k = KIND_NOT;
      ">":     k = KIND_GT;
      "<":     k = KIND_LT;
      default: k = KIND_ERROR;
    endcase
    return k;
  endfunction

endpackage

// ===== rtl/etl_scan.sv =====
// Lexer scan state and per-byte decision logic producing one token group per byte.
module etl_scan (
  input  logic            clk,
  input  logic            rst,
  input  logic            take,
  input  etl_pkg::byte_t  byte_data,
  output etl_pkg::group_t group_data
);

  typedef enum logic [2:0] {
    M_IDLE,
    M_SYM,
    M_ZNUM,
    M_DEC,
    M_ESIGN,
    M_EDIG,
    M_SUFFIX,
    M_HELD
  } mode_t;

  // Scan state
  mode_t       mode;
  logic [7:0]  held;
  logic [31:0] start;
  logic [15:0] len;
  logic [15:0] scol;
  logic [31:0] offset;
  logic [23:0] line;
  logic [15:0] col;
  logic        drop;

  mode_t       mode_next;
  logic [7:0]  held_next;
  logic [31:0] start_next;
  logic [15:0] len_next;
  logic [15:0] scol_next;
  logic [31:0] offset_next;
  logic [23:0] line_next;
  logic [15:0] col_next;
  logic        drop_next;

  logic [7:0]  b;
  logic        do_fresh;
  logic        end_num;
  logic [4:0]  pk;
  logic [4:0]  sk;
  logic [1:0]  n;
  etl_pkg::token_t [etl_pkg::MAX_TOKENS-1:0] items;

  assign b = byte_data.data_byte;

  // Per-byte step: process, advance counters, flush on the final byte
  always_comb begin
    mode_next   = mode;
    held_next   = held;
    start_next  = start;
    len_next    = len;
    scol_next   = scol;
    drop_next   = drop;
    do_fresh    = 1'b0;
    end_num     = 1'b0;
    pk          = etl_pkg::pair_kind(held, b);
    sk          = etl_pkg::single_kind(held);
    n           = 2'd0;
    items       = '0;

    if (!drop) begin
      case (mode)
        M_SYM: begin
          if (etl_pkg::is_alpha(b) || etl_pkg::is_digit(b)) begin
            if (len_next < etl_pkg::LEN_MAX) len_next = len_next + 16'd1;
          end else begin
            items[n] = etl_pkg::make_token(etl_pkg::KIND_SYMBOL, start_next, len_next,
                                           line, scol_next);
            n = n + 2'd1;
            mode_next = M_IDLE;
            do_fresh  = 1'b1;
          end
        end
        M_ZNUM: begin
          if (etl_pkg::is_hexset(b)) begin
            if (len_next < etl_pkg::LEN_MAX) len_next = len_next + 16'd1;
          end else begin
            end_num = 1'b1;
          end
        end
        M_DEC: begin
          if (etl_pkg::is_digit(b) || (b == ".")) begin
            if (len_next < etl_pkg::LEN_MAX) len_next = len_next + 16'd1;
          end else if ((b == "e") || (b == "E")) begin
            if (len_next < etl_pkg::LEN_MAX) len_next = len_next + 16'd1;
            mode_next = M_ESIGN;
          end else begin
            end_num = 1'b1;
          end
        end
        M_ESIGN: begin
          if ((b == "+") || (b == "-") || etl_pkg::is_digit(b)) begin
            if (len_next < etl_pkg::LEN_MAX) len_next = len_next + 16'd1;
            mode_next = M_EDIG;
          end else begin
            end_num = 1'b1;
          end
        end
        M_EDIG: begin
          if (etl_pkg::is_digit(b)) begin
            if (len_next < etl_pkg::LEN_MAX) len_next = len_next + 16'd1;
          end else begin
            end_num = 1'b1;
          end
        end
        M_SUFFIX: begin
          if (!etl_pkg::is_suffix(b)) begin
            mode_next = M_IDLE;
            do_fresh  = 1'b1;
          end
        end
        M_HELD: begin
          mode_next = M_IDLE;
          held_next = 8'd0;
          if (pk != etl_pkg::KIND_SYMBOL) begin
            items[n] = etl_pkg::make_token(pk, start_next, 16'd2, line, scol_next);
            n = n + 2'd1;
          end else begin
            items[n] = etl_pkg::make_token(sk, start_next, 16'd1, line, scol_next);
            n = n + 2'd1;
            if (sk == etl_pkg::KIND_ERROR) drop_next = 1'b1;
            else do_fresh = 1'b1;
          end
        end
        default: begin
          mode_next = M_IDLE;
          do_fresh  = 1'b1;
        end
      endcase

      // Number ended: emit it, then skip a suffix or restart on this byte
      if (end_num) begin
        items[n] = etl_pkg::make_token(etl_pkg::KIND_NUMBER, start_next, len_next,
                                       line, scol_next);
        n = n + 2'd1;
        if (etl_pkg::is_suffix(b)) begin
          mode_next = M_SUFFIX;
        end else begin
          mode_next = M_IDLE;
          do_fresh  = 1'b1;
        end
      end

      // Byte seen with no token open
      if (do_fresh) begin
        case (b) inside
          8'h20, 8'h09, 8'h0B, 8'h0D, 8'h0A: begin
          end
          "(", ")", ",", "^", "%", "+", "-", "~": begin
            case (b)
              "(":     items[n] = etl_pkg::make_token(etl_pkg::KIND_LPAREN, offset,
                                                      16'd1, line, col);
              ")":     items[n] = etl_pkg::make_token(etl_pkg::KIND_RPAREN, offset,
                                                      16'd1, line, col);
              ",":     items[n] = etl_pkg::make_token(etl_pkg::KIND_COMMA, offset,
                                                      16'd1, line, col);
              "^":     items[n] = etl_pkg::make_token(etl_pkg::KIND_CARET, offset,
                                                      16'd1, line, col);
              "%":     items[n] = etl_pkg::make_token(etl_pkg::KIND_PERCENT, offset,
                                                      16'd1, line, col);
              "+":     items[n] = etl_pkg::make_token(etl_pkg::KIND_PLUS, offset,
                                                      16'd1, line, col);
              "-":     items[n] = etl_pkg::make_token(etl_pkg::KIND_MINUS, offset,
                                                      16'd1, line, col);
              default: items[n] = etl_pkg::make_token(etl_pkg::KIND_TILDE, offset,
                                                      16'd1, line, col);
            endcase
            n = n + 2'd1;
          end
          "/", "*", "|", "&", "!", "=", ">", "<": begin
            mode_next  = M_HELD;
            held_next  = b;
            start_next = offset;
            scol_next  = col;
            len_next   = 16'd1;
          end
          default: begin
            if (etl_pkg::is_alpha(b) || etl_pkg::is_digit(b)) begin
              if (etl_pkg::is_alpha(b)) mode_next = M_SYM;
              else if (b == "0") mode_next = M_ZNUM;
              else mode_next = M_DEC;
              start_next = offset;
              scol_next  = col;
              len_next   = 16'd1;
            end else begin
              items[n] = etl_pkg::make_token(etl_pkg::KIND_ERROR, offset, 16'd1, line, col);
              n = n + 2'd1;
              drop_next = 1'b1;
            end
          end
        endcase
      end
    end

    // Position counters
    offset_next = offset + 32'd1;
    line_next   = line;
    col_next    = col;
    if (b == 8'h0A) begin
      if (line < etl_pkg::LINE_MAX) line_next = line + 24'd1;
      col_next = 16'd0;
    end else if (col < etl_pkg::COL_MAX) begin
      col_next = col + 16'd1;
    end

    // Final byte: flush the open token, then the end token, then start over
    if (byte_data.last_byte) begin
      if (!drop_next) begin
        case (mode_next)
          M_SYM: begin
            items[n] = etl_pkg::make_token(etl_pkg::KIND_SYMBOL, start_next, len_next,
                                           line_next, scol_next);
            n = n + 2'd1;
          end
          M_ZNUM, M_DEC, M_ESIGN, M_EDIG: begin
            items[n] = etl_pkg::make_token(etl_pkg::KIND_NUMBER, start_next, len_next,
                                           line_next, scol_next);
            n = n + 2'd1;
          end
          M_HELD: begin
            items[n] = etl_pkg::make_token(etl_pkg::single_kind(held_next), start_next,
                                           16'd1, line_next, scol_next);
            n = n + 2'd1;
          end
          default: begin
          end
        endcase
      end
      items[n] = etl_pkg::make_token(etl_pkg::KIND_END, offset_next, 16'd0,
                                     line_next, col_next);
      n = n + 2'd1;
      mode_next   = M_IDLE;
      held_next   = 8'd0;
      start_next  = 32'd0;
      len_next    = 16'd0;
      scol_next   = 16'd0;
      offset_next = 32'd0;
      line_next   = 24'd0;
      col_next    = 16'd0;
      drop_next   = 1'b0;
    end
  end

  assign group_data.cnt  = n;
  assign group_data.item = items;

  // State update on each accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= M_IDLE;
      held   <= 8'd0;
      start  <= 32'd0;
      len    <= 16'd0;
      scol   <= 16'd0;
      offset <= 32'd0;
      line   <= 24'd0;
      col    <= 16'd0;
      drop   <= 1'b0;
    end else if (take) begin
      mode   <= mode_next;
      held   <= held_next;
      start  <= start_next;
      len    <= len_next;
      scol   <= scol_next;
      offset <= offset_next;
      line   <= line_next;
      col    <= col_next;
      drop   <= drop_next;
    end
  end

endmodule

// ===== rtl/etl_outq.sv =====
// Two-entry token group queue, one token per cycle while token_ready.
module etl_outq (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  etl_pkg::group_t  group_data,
  output logic             ready,
  output logic             token_valid,
  input  logic             token_ready,
  output etl_pkg::token_t  token_data
);

  etl_pkg::group_t mem [2];
  logic [1:0] count;
  logic       head;
  logic       tail;
  logic [1:0] sel;
  logic [1:0] last_sel;
  logic       fire;
  logic       pop;

  assign ready       = (count != 2'd2);
  assign token_valid = (count != 2'd0);
  assign last_sel    = mem[head].cnt - 2'd1;
  assign fire        = token_valid && token_ready;
  assign pop         = fire && (sel == last_sel);

  // Current token of the head group, flagged when it closes the group
  always_comb begin
    token_data             = mem[head].item[sel];
    token_data.last_result = (sel == last_sel);
  end

  // Group storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[tail] <= group_data;
    end
  end

  // Pointers, fill count and token select
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
      head  <= 1'b0;
      tail  <= 1'b0;
      sel   <= 2'd0;
    end else begin
      if (push) tail <= ~tail;
      if (fire) begin
        if (pop) begin
          sel  <= 2'd0;
          head <= ~head;
        end else begin
          sel <= sel + 2'd1;
        end
      end
      if (push && !pop) count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

endmodule

// ===== rtl/expression_token_lexer_core.sv =====
// Top level of the expression lexer: byte scanner feeding a token queue.
//
//   channel | direction | handshake                 | payload
//   byte    | in        | byte_valid / byte_ready   | etl_pkg::byte_t  byte_data
//   token   | out       | token_valid / token_ready | etl_pkg::token_t token_data
//
// One byte is accepted per cycle while byte_ready is high; its tokens (0 to 3) are
// registered as a group and leave the token port one per cycle while token_ready is high.
// A two-group queue sits between the scanner and the token port, so byte_ready
// drops only while both groups are held; a stalled token port stalls bytes then.
// Reset (rst, synchronous) returns the scanner to offset 0, line 0, column 0 and
// empties the queue; the final byte of a source does the same for the scanner.
module expression_token_lexer_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             byte_valid,
  output logic             byte_ready,
  input  etl_pkg::byte_t   byte_data,
  output logic             token_valid,
  input  logic             token_ready,
  output etl_pkg::token_t  token_data
);

  logic            take;
  logic            push;
  etl_pkg::group_t group_data;

  assign take = byte_valid && byte_ready;
  assign push = take && (group_data.cnt != 2'd0);

  etl_scan u_scan (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .byte_data  (byte_data),
    .group_data (group_data)
  );

  etl_outq u_outq (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .group_data  (group_data),
    .ready       (byte_ready),
    .token_valid (token_valid),
    .token_ready (token_ready),
    .token_data  (token_data)
  );

endmodule

// ===== test/expression_token_lexer_core_tb.sv =====
// Self-checking testbench for expression_token_lexer_core: byte requests in, tokens checked.
module expression_token_lexer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned DRAIN_CYCLES   = 16;
  localparam int unsigned PHASE_BYTES    = 75;

  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_VT  = 8'h0B;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_SP  = 8'h20;

  localparam logic [26*8-1:0] ZNUM_CHARS   = "xXbB0123456789abcdefABCDEF";
  localparam logic [16*8-1:0] OP_CHARS     = "()^%+-~,/*|&!=<>";
  localparam logic [4*8-1:0]  SUFFIX_CHARS = "LUlu";
  localparam logic [5*8-1:0]  WS_CHARS     = {CH_SP, CH_TAB, CH_VT, CH_CR, CH_LF};

  typedef enum logic [2:0] {
    S_IDLE, S_SYM, S_ZNUM, S_DEC, S_ESIGN, S_EDIG, S_SUFFIX, S_HELD
  } scan_t;

  // One directed request; hand_checked rows carry their single expected token
  typedef struct packed {
    logic [7:0]      ch;
    logic            lst;
    logic            hand_checked;
    etl_pkg::token_t tok;
  } stim_row_t;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            byte_valid = 1'b0;
  logic            byte_ready;
  etl_pkg::byte_t  byte_data = '0;
  logic            token_valid;
  logic            token_ready = 1'b0;
  etl_pkg::token_t token_data;

  // Scanner state mirrored by the predictor
  scan_t       mode;
  logic [7:0]  held;
  logic [31:0] tok_off;
  logic [15:0] tok_len;
  logic [15:0] tok_col;
  logic [31:0] src_off;
  logic [23:0] src_line;
  logic [15:0] src_col;
  logic        dropping;

  etl_pkg::token_t step_tok [3];
  int              step_n;
  etl_pkg::token_t tokens_due [$];
  logic [7:0]      src_bytes [$];

  int unsigned valid_gap_pct = 0;
  int unsigned ready_drop_pct = 0;
  int unsigned hold_asks = 0;
  int unsigned hold_given = 0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned bytes_sent = 0;
  int unsigned sources_sent = 0;
  int unsigned tokens_checked = 0;
  int unsigned fails = 0;
  etl_pkg::token_t want;

  stim_row_t directed_rows [25] = '{
    '{"(",    1'b0, 1'b1, '{etl_pkg::KIND_LPAREN, 32'd0, 16'd1, 24'd0, 16'd0, 1'b1}},
    '{"a",    1'b0, 1'b0, '0},
    '{"9",    1'b0, 1'b0, '0},
    '{CH_SP,  1'b0, 1'b0, '0},
    '{"0",    1'b0, 1'b0, '0},
    '{"x",    1'b0, 1'b0, '0},
    '{"F",    1'b0, 1'b0, '0},
    '{"u",    1'b0, 1'b0, '0},
    '{"L",    1'b0, 1'b0, '0},
    '{CH_LF,  1'b0, 1'b0, '0},
    '{"1",    1'b0, 1'b0, '0},
    '{"e",    1'b0, 1'b0, '0},
    '{"-",    1'b0, 1'b0, '0},
    '{"7",    1'b0, 1'b0, '0},
    '{">",    1'b0, 1'b0, '0},
    '{">",    1'b0, 1'b0, '0},
    '{"!",    1'b0, 1'b0, '0},
    '{"x",    1'b0, 1'b0, '0},
    '{"=",    1'b0, 1'b0, '0},
    // lone '=' before '+': error at the '=', then everything dropped
    '{"+",    1'b0, 1'b1, '{etl_pkg::KIND_ERROR, 32'd18, 16'd1, 24'd1, 16'd8, 1'b1}},
    '{8'hFF,  1'b1, 1'b1, '{etl_pkg::KIND_END, 32'd21, 16'd0, 24'd1, 16'd11, 1'b1}},
    // high byte opens a new source with an error
    '{8'h80,  1'b0, 1'b1, '{etl_pkg::KIND_ERROR, 32'd0, 16'd1, 24'd0, 16'd0, 1'b1}},
    '{"1",    1'b1, 1'b1, '{etl_pkg::KIND_END, 32'd2, 16'd0, 24'd0, 16'd2, 1'b1}},
    // held operator flushed by the final byte, then NUL as a final byte
    '{"<",    1'b1, 1'b0, '0},
    '{8'h00,  1'b1, 1'b0, '0}
  };

  expression_token_lexer_core dut (
    .clk         (clk),
    .rst         (rst),
    .byte_valid  (byte_valid),
    .byte_ready  (byte_ready),
    .byte_data   (byte_data),
    .token_valid (token_valid),
    .token_ready (token_ready),
    .token_data  (token_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Character classes
  function automatic logic c_digit(input logic [7:0] b);
    return (b >= "0") && (b <= "9");
  endfunction

  function automatic logic c_letter(input logic [7:0] b);
    return ((b >= "A") && (b <= "Z")) || ((b >= "a") && (b <= "z"));
  endfunction

  function automatic logic c_hex(input logic [7:0] b);
    return c_digit(b) || (b == "x") || (b == "X") || (b == "b") || (b == "B") ||
           ((b >= "a") && (b <= "f")) || ((b >= "A") && (b <= "F"));
  endfunction

  function automatic logic c_suffix(input logic [7:0] b);
    return (b == "L") || (b == "U") || (b == "l") || (b == "u");
  endfunction

  task automatic clear_scanner();
    mode     = S_IDLE;
    held     = 8'd0;
    tok_off  = '0;
    tok_len  = '0;
    tok_col  = '0;
    src_off  = '0;
    src_line = '0;
    src_col  = '0;
    dropping = 1'b0;
  endtask

  task automatic add_token(input logic [4:0] k, input logic [31:0] s, input logic [15:0] l,
                           input logic [23:0] ln, input logic [15:0] c);
    if (step_n < 3) begin
      step_tok[step_n] = '{token_kind: k, token_start: s, token_length: l,
                           line_number: ln, column_number: c, last_result: 1'b0};
      step_n++;
    end
  endtask

  task automatic open_token(input scan_t m);
    mode    = m;
    tok_off = src_off;
    tok_col = src_col;
    tok_len = 16'd1;
  endtask

  task automatic extend_token();
    if (tok_len != etl_pkg::LEN_MAX) tok_len++;
  endtask

  // Held operator with no partner: one-character form, or an error for '='
  task automatic resolve_held(output logic ok);
    logic [4:0] k;
    case (held)
      "/":     k = etl_pkg::KIND_SLASH;
      "*":     k = etl_pkg::KIND_STAR;
      "|":     k = etl_pkg::KIND_OR;
      "&":     k = etl_pkg::KIND_AND;
      "!":     k = etl_pkg::KIND_NOT;
      ">":     k = etl_pkg::KIND_GT;
      "<":     k = etl_pkg::KIND_LT;
      default: k = etl_pkg::KIND_ERROR;
    endcase
    add_token(k, tok_off, 16'd1, src_line, tok_col);
    mode = S_IDLE;
    held = 8'd0;
    ok = (k != etl_pkg::KIND_ERROR);
    if (!ok) dropping = 1'b1;
  endtask

  // Byte seen with no token open
  task automatic start_fresh(input logic [7:0] b);
    case (b)
      CH_SP, CH_TAB, CH_VT, CH_CR, CH_LF: ;
      "(": add_token(etl_pkg::KIND_LPAREN, src_off, 16'd1, src_line, src_col);
      ")": add_token(etl_pkg::KIND_RPAREN, src_off, 16'd1, src_line, src_col);
      ",": add_token(etl_pkg::KIND_COMMA, src_off, 16'd1, src_line, src_col);
      "^": add_token(etl_pkg::KIND_CARET, src_off, 16'd1, src_line, src_col);
      "%": add_token(etl_pkg::KIND_PERCENT, src_off, 16'd1, src_line, src_col);
      "+": add_token(etl_pkg::KIND_PLUS, src_off, 16'd1, src_line, src_col);
      "-": add_token(etl_pkg::KIND_MINUS, src_off, 16'd1, src_line, src_col);
      "~": add_token(etl_pkg::KIND_TILDE, src_off, 16'd1, src_line, src_col);
      "/", "*", "|", "&", "!", "=", ">", "<": begin
        open_token(S_HELD);
        held = b;
      end
      default: begin
        if (c_letter(b)) open_token(S_SYM);
        else if (b == "0") open_token(S_ZNUM);
        else if (c_digit(b)) open_token(S_DEC);
        else begin
          add_token(etl_pkg::KIND_ERROR, src_off, 16'd1, src_line, src_col);
          dropping = 1'b1;
        end
      end
    endcase
  endtask

  // Number ended by b: suffix letters are swallowed, anything else starts over
  task automatic finish_number(input logic [7:0] b);
    add_token(etl_pkg::KIND_NUMBER, tok_off, tok_len, src_line, tok_col);
    if (c_suffix(b)) mode = S_SUFFIX;
    else begin
      mode = S_IDLE;
      start_fresh(b);
    end
  endtask

  task automatic lex_byte(input logic [7:0] b);
    logic [4:0] k;
    logic       paired;
    logic       ok;
    case (mode)
      S_SYM: begin
        if (c_letter(b) || c_digit(b)) extend_token();
        else begin
          add_token(etl_pkg::KIND_SYMBOL, tok_off, tok_len, src_line, tok_col);
          mode = S_IDLE;
          start_fresh(b);
        end
      end
      S_ZNUM: begin
        if (c_hex(b)) extend_token();
        else finish_number(b);
      end
      S_DEC: begin
        if (c_digit(b) || (b == ".")) extend_token();
        else if ((b == "e") || (b == "E")) begin
          extend_token();
          mode = S_ESIGN;
        end else finish_number(b);
      end
      S_ESIGN: begin
        if ((b == "+") || (b == "-") || c_digit(b)) begin
          extend_token();
          mode = S_EDIG;
        end else finish_number(b);
      end
      S_EDIG: begin
        if (c_digit(b)) extend_token();
        else finish_number(b);
      end
      S_SUFFIX: begin
        if (!c_suffix(b)) begin
          mode = S_IDLE;
          start_fresh(b);
        end
      end
      S_HELD: begin
        k = etl_pkg::KIND_SYMBOL;
        paired = 1'b1;
        case ({held, b})
          "//":    k = etl_pkg::KIND_DSLASH;
          "**":    k = etl_pkg::KIND_DSTAR;
          "||":    k = etl_pkg::KIND_OROR;
          "&&":    k = etl_pkg::KIND_ANDAND;
          "!=":    k = etl_pkg::KIND_NE;
          "==":    k = etl_pkg::KIND_EQ;
          ">=":    k = etl_pkg::KIND_GE;
          ">>":    k = etl_pkg::KIND_SHR;
          "<=":    k = etl_pkg::KIND_LE;
          "<<":    k = etl_pkg::KIND_SHL;
          default: paired = 1'b0;
        endcase
        if (paired) begin
          add_token(k, tok_off, 16'd2, src_line, tok_col);
          mode = S_IDLE;
          held = 8'd0;
        end else begin
          resolve_held(ok);
          if (ok) start_fresh(b);
        end
      end
      default: start_fresh(b);
    endcase
  endtask

  // Tokens caused by one accepted byte, left in step_tok[0 .. step_n-1]
  task automatic scan_byte(input logic [7:0] b, input logic lst);
    logic ok;
    step_n = 0;
    if (!dropping) lex_byte(b);
    src_off++;
    if (b == CH_LF) begin
      if (src_line != etl_pkg::LINE_MAX) src_line++;
      src_col = '0;
    end else if (src_col != etl_pkg::COL_MAX) begin
      src_col++;
    end
    if (lst) begin
      if (!dropping) begin
        case (mode)
          S_SYM: add_token(etl_pkg::KIND_SYMBOL, tok_off, tok_len, src_line, tok_col);
          S_ZNUM, S_DEC, S_ESIGN, S_EDIG:
            add_token(etl_pkg::KIND_NUMBER, tok_off, tok_len, src_line, tok_col);
          S_HELD: resolve_held(ok);
          default: ;
        endcase
      end
      add_token(etl_pkg::KIND_END, src_off, 16'd0, src_line, src_col);
      clear_scanner();
    end
    if (step_n > 0) step_tok[step_n-1].last_result = 1'b1;
  endtask

  // Send one request, with random gaps before it, and log what it should produce
  task automatic offer_byte(input logic [7:0] ch, input logic lst,
                            input logic hand_checked, input etl_pkg::token_t tok);
    while ($urandom_range(99) < valid_gap_pct) begin
      byte_valid <= 1'b0;
      @(posedge clk);
    end
    byte_valid <= 1'b1;
    byte_data  <= '{data_byte: ch, last_byte: lst};
    @(posedge clk);
    while (!byte_ready) @(posedge clk);
    scan_byte(ch, lst);
    if (hand_checked) tokens_due.push_back(tok);
    else for (int i = 0; i < step_n; i++) tokens_due.push_back(step_tok[i]);
    bytes_sent++;
  endtask

  function automatic logic [7:0] rand_letter();
    int unsigned i;
    i = $urandom_range(51);
    return (i < 26) ? 8'("A" + i) : 8'("a" + i - 26);
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'("0" + $urandom_range(9));
  endfunction

  task automatic add_suffix();
    if ($urandom_range(9) < 3)
      repeat ($urandom_range(1, 2)) src_bytes.push_back(SUFFIX_CHARS[8*$urandom_range(3) +: 8]);
  endtask

  // Append one lexical piece: mostly well-formed tokens, some whitespace, a little noise
  task automatic add_piece();
    int unsigned pick;
    logic [7:0]  c;
    pick = $urandom_range(99);
    if (pick < 20) begin
      src_bytes.push_back(rand_letter());
      repeat ($urandom_range(5))
        src_bytes.push_back(($urandom_range(2) == 0) ? rand_digit() : rand_letter());
    end else if (pick < 32) begin
      src_bytes.push_back("0");
      repeat ($urandom_range(4)) src_bytes.push_back(ZNUM_CHARS[8*$urandom_range(25) +: 8]);
      add_suffix();
    end else if (pick < 48) begin
      src_bytes.push_back(8'("1" + $urandom_range(8)));
      repeat ($urandom_range(4))
        src_bytes.push_back(($urandom_range(3) == 0) ? 8'(".") : rand_digit());
      if ($urandom_range(1)) begin
        src_bytes.push_back($urandom_range(1) ? 8'("e") : 8'("E"));
        if ($urandom_range(1)) src_bytes.push_back($urandom_range(1) ? 8'("+") : 8'("-"));
        repeat ($urandom_range(2)) src_bytes.push_back(rand_digit());
      end
      add_suffix();
    end else if (pick < 73) begin
      c = OP_CHARS[8*$urandom_range(15) +: 8];
      src_bytes.push_back(c);
      // '=' always gets its partner so that most sources stay error free
      if ((c == "=") || $urandom_range(1)) begin
        case (c)
          "/", "*", "|", "&", "=": src_bytes.push_back(c);
          "!":                     src_bytes.push_back("=");
          ">", "<":                src_bytes.push_back($urandom_range(1) ? 8'("=") : c);
          default: ;
        endcase
      end
    end else if (pick < 95) begin
      src_bytes.push_back(WS_CHARS[8*$urandom_range(4) +: 8]);
    end else begin
      src_bytes.push_back(8'($urandom_range(255)));
    end
  endtask

  // Token side: check each accepted token, then pick ready for the next cycle
  always @(posedge clk) begin
    if (!rst && token_valid && token_ready) begin
      tokens_checked++;
      if (tokens_due.size() == 0) begin
        $error("token with nothing expected: kind %0d start %0d",
               token_data.token_kind, token_data.token_start);
        fails++;
      end else begin
        want = tokens_due.pop_front();
        if (token_data.token_kind != want.token_kind) begin
          $error("token_kind: expected %0d, got %0d", want.token_kind, token_data.token_kind);
          fails++;
        end
        if (token_data.token_start != want.token_start) begin
          $error("token_start: expected %0d, got %0d", want.token_start, token_data.token_start);
          fails++;
        end
        if (token_data.token_length != want.token_length) begin
          $error("token_length: expected %0d, got %0d",
                 want.token_length, token_data.token_length);
          fails++;
        end
        if (token_data.line_number != want.line_number) begin
          $error("line_number: expected %0d, got %0d", want.line_number, token_data.line_number);
          fails++;
        end
        if (token_data.column_number != want.column_number) begin
          $error("column_number: expected %0d, got %0d",
                 want.column_number, token_data.column_number);
          fails++;
        end
        if (token_data.last_result != want.last_result) begin
          $error("last_result: expected %0d, got %0d", want.last_result, token_data.last_result);
          fails++;
        end
      end
    end
    if (hold_left != 0) begin
      hold_left--;
      token_ready <= 1'b0;
    end else if (hold_given != hold_asks) begin
      hold_given = hold_asks;
      hold_left  = HOLD_CYCLES;
      token_ready <= 1'b0;
    end else begin
      token_ready <= ($urandom_range(99) >= ready_drop_pct);
    end
  end

  // Watchdog: too long without any request or token moving
  always @(posedge clk) begin
    if ((byte_valid && byte_ready) || (token_valid && token_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned target;
    int unsigned phase_end;
    clear_scanner();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed table
    for (int r = 0; r < 25; r++)
      offer_byte(directed_rows[r].ch, directed_rows[r].lst,
                 directed_rows[r].hand_checked, directed_rows[r].tok);
    sources_sent = 4;

    // Random sources under four idle/stall mixes
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin valid_gap_pct = 0;  ready_drop_pct = 0;  end
        1: begin valid_gap_pct = 49; ready_drop_pct = 0;  end
        2: begin valid_gap_pct = 0;  ready_drop_pct = 49; end
        default: begin valid_gap_pct = 23; ready_drop_pct = 23; end
      endcase
      // long token-side hold-off while requests keep coming: the queue fills up
      if (phase == 0) hold_asks++;
      phase_end = bytes_sent + PHASE_BYTES;
      while (bytes_sent < phase_end) begin
        src_bytes.delete();
        target = $urandom_range(2, 24);
        while (src_bytes.size() < target) add_piece();
        for (int i = 0; i < src_bytes.size(); i++)
          offer_byte(src_bytes[i], i == src_bytes.size() - 1, 1'b0, '0);
        sources_sent++;
      end
    end
    byte_valid <= 1'b0;

    while (tokens_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d bytes in %0d sources, including a long token-side hold-off,",
             bytes_sent, sources_sent);
    $display("under four sender/receiver stall mixes; %0d tokens checked, %0d mismatches.",
             tokens_checked, fails);
    if (fails == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
